/* rtl/dcss_pkg.sv */
// dcss_pkg: shared types and constants for the delta-coded successor search
// holds request and register codes, the sample entry layout and the sequencer states
// no dependencies
`default_nettype none

package dcss_pkg;

  localparam int unsigned CODE_W = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned IDX_W  = 18;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_DELTA  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [2:0] REG_FIRST_CODE   = 3'd0;
  localparam logic [2:0] REG_CODE_COUNT   = 3'd1;
  localparam logic [2:0] REG_DIFF_MASK    = 3'd2;
  localparam logic [2:0] REG_SEARCH_DEPTH = 3'd3;
  localparam logic [2:0] REG_CACHE_ENABLE = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LO_RD,
    ST_LO_DATA,
    ST_HI_RD,
    ST_HI_DATA,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/delta_coded_successor_search.sv */
// delta_coded_successor_search: first code not below a query in a delta-coded list
// sample cache and difference words live in two synchronous memories
// depends on dcss_pkg
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser req_type, tdata position, value
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tuser found, tdata found_index, found_code
//  cfg     | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// load requests are written while idle; a query searches the sample cache when enabled
// (up to search_depth + 1 levels), reads the bracketing samples, then scans difference words
// the scan issues one difference read per cycle, set by the single read port
// no clearing pass after reset; the output register frees the input while a result waits
`default_nettype none

module delta_coded_successor_search
  import dcss_pkg::*;
#(
  parameter int unsigned SAMPLE_ENTRIES = 1024,
  parameter int unsigned LIST_ENTRIES   = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // position[15:0], value[47:16]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // found_index[15:0], found_code[47:16]
  output logic             m_axis_tuser,  // found[0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned SAW  = $clog2(SAMPLE_ENTRIES);
  localparam int unsigned SFW  = $clog2(SAMPLE_ENTRIES + 1);
  localparam int unsigned SIW  = SFW + 1;
  localparam int unsigned DAW  = $clog2(LIST_ENTRIES);
  localparam int          LAST = int'(LIST_ENTRIES) - 1;

  // configuration
  logic [CODE_W-1:0] first_code_q;
  logic [CNT_W-1:0]  code_count_q;
  logic [CODE_W-1:0] diff_mask_q;
  logic [3:0]        depth_q;
  logic              cache_en_q;

  // memories
  sample_t           smp_mem [SAMPLE_ENTRIES];
  logic [CODE_W-1:0] dlt_mem [LIST_ENTRIES];
  sample_t           smp_rdata_q;
  logic [CODE_W-1:0] dlt_rdata_q;
  logic              smp_we, smp_re, dlt_we, dlt_re;
  logic [SAW-1:0]    smp_raddr;
  logic [DAW-1:0]    dlt_raddr;

  // sequencer state
  state_e                 state_q, state_d;
  logic [SFW-1:0]         fill_q, fill_d;
  logic [CODE_W-1:0]      qcode_q, qcode_d;
  logic signed [SIW-1:0]  l_q, l_d, r_q, r_d, m_q, m_d;
  logic [3:0]             level_q, level_d;
  logic                   lo_rd_q, lo_rd_d, hi_rd_q, hi_rd_d;
  logic [SAW-1:0]         lo_addr_q, lo_addr_d, hi_addr_q, hi_addr_d;
  logic signed [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CODE_W-1:0]      prev_q, prev_d;
  logic                   pend_q, pend_d;
  logic [POS_W-1:0]       pend_idx_q, pend_idx_d;
  logic                   hit_q, hit_d;
  logic [POS_W-1:0]       hit_idx_q, hit_idx_d;
  logic [CODE_W-1:0]      hit_code_q, hit_code_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [POS_W-1:0]  out_idx_q, out_idx_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;

  // shared conditions
  logic [POS_W-1:0]      in_pos;
  logic [CODE_W-1:0]     in_val;
  logic                  acc, q_low, use_cache;
  logic signed [SIW-1:0] fill_s, r_init, m_w, r_inc;
  logic                  srch_empty, s_eq, s_lt, deeper, r_inc_ok;
  logic [CODE_W-1:0]     sum;
  int                    hi_lim;
  logic                  hit_now, issue, finish, out_free;

  assign in_pos     = s_axis_tdata[15:0];
  assign in_val     = s_axis_tdata[47:16];
  assign acc        = s_axis_tvalid && s_axis_tready;
  assign q_low      = in_val <= first_code_q;
  assign use_cache  = cache_en_q && (fill_q != '0);
  assign fill_s     = $signed({1'b0, fill_q});
  assign r_init     = fill_s - SIW'(1);
  assign m_w        = l_q + ((r_q - l_q) >>> 1);
  assign r_inc      = r_q + SIW'(1);
  assign r_inc_ok   = r_inc < fill_s;
  assign srch_empty = l_q > r_q;
  assign s_eq       = qcode_q == smp_rdata_q.code;
  assign s_lt       = qcode_q < smp_rdata_q.code;
  assign deeper     = level_q < depth_q;
  assign sum        = prev_q + (dlt_rdata_q & diff_mask_q);
  assign hi_lim     = (int'(hi_q) > LAST) ? LAST : int'(hi_q);
  assign hit_now    = pend_q && (qcode_q <= sum);
  assign issue      = !hit_now && (int'(lo_q) <= hi_lim);
  assign finish     = !hit_now && !issue && !pend_q;
  assign out_free   = !out_valid_q || m_axis_tready;

  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {out_code_q, out_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_code_q <= '0;
      code_count_q <= CNT_W'(1);
      diff_mask_q  <= '1;
      depth_q      <= '0;
      cache_en_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FIRST_CODE:   first_code_q <= cfg_data_i;
        REG_CODE_COUNT:   code_count_q <= cfg_data_i[CNT_W-1:0];
        REG_DIFF_MASK:    diff_mask_q  <= cfg_data_i;
        REG_SEARCH_DEPTH: depth_q      <= cfg_data_i[3:0];
        REG_CACHE_ENABLE: cache_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[fill_q[SAW-1:0]] <= '{pos: in_pos, code: in_val};
    end
    if (smp_re) begin
      smp_rdata_q <= smp_mem[smp_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dlt_we) begin
      dlt_mem[DAW'(in_pos)] <= in_val;
    end
    if (dlt_re) begin
      dlt_rdata_q <= dlt_mem[dlt_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && s_axis_tuser == REQ_QUERY) begin
          if (q_low) state_d = ST_DONE;
          else if (use_cache) state_d = ST_SRCH_RD;
          else state_d = ST_LO_RD;
        end
      end
      ST_SRCH_RD:  state_d = srch_empty ? ST_LO_RD : ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (s_eq) state_d = ST_DONE;
        else if (deeper) state_d = ST_SRCH_RD;
        else state_d = ST_LO_RD;
      end
      ST_LO_RD:   state_d = lo_rd_q ? ST_LO_DATA : ST_HI_RD;
      ST_LO_DATA: state_d = ST_HI_RD;
      ST_HI_RD:   state_d = hi_rd_q ? ST_HI_DATA : ST_SCAN;
      ST_HI_DATA: state_d = ST_SCAN;
      ST_SCAN:    state_d = (hit_now || finish) ? ST_DONE : ST_SCAN;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    fill_d      = fill_q;
    qcode_d     = qcode_q;
    l_d         = l_q;
    r_d         = r_q;
    m_d         = m_q;
    level_d     = level_q;
    lo_rd_d     = lo_rd_q;
    hi_rd_d     = hi_rd_q;
    lo_addr_d   = lo_addr_q;
    hi_addr_d   = hi_addr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    prev_d      = prev_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_code_d  = hit_code_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_code_d  = out_code_q;
    smp_we      = 1'b0;
    smp_re      = 1'b0;
    smp_raddr   = lo_addr_q;
    dlt_we      = 1'b0;
    dlt_re      = 1'b0;
    dlt_raddr   = DAW'(lo_q);

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          qcode_d = in_val;
          hit_d   = 1'b0;
          lo_rd_d = 1'b0;
          hi_rd_d = 1'b0;
          l_d     = '0;
          r_d     = r_init;
          level_d = '0;
          if (s_axis_tuser == REQ_SAMPLE && 32'(fill_q) < 32'(SAMPLE_ENTRIES)) begin
            smp_we = 1'b1;
            fill_d = fill_q + SFW'(1);
          end
          if (s_axis_tuser == REQ_DELTA && 32'(in_pos) < 32'(LIST_ENTRIES)) begin
            dlt_we = 1'b1;
          end
          if (s_axis_tuser == REQ_QUERY && q_low) begin
            hit_d      = 1'b1;
            hit_idx_d  = '0;
            hit_code_d = first_code_q;
          end
        end
      end
      ST_SRCH_RD: begin
        if (srch_empty) begin
          lo_rd_d   = l_q > 0;
          lo_addr_d = SAW'(l_q - SIW'(1));
          hi_rd_d   = r_inc_ok;
          hi_addr_d = SAW'(r_inc);
        end else begin
          smp_re    = 1'b1;
          smp_raddr = SAW'(m_w);
          m_d       = m_w;
        end
      end
      ST_SRCH_CMP: begin
        if (s_eq) begin
          hit_d      = 1'b1;
          hit_idx_d  = smp_rdata_q.pos;
          hit_code_d = smp_rdata_q.code;
        end else if (s_lt) begin
          hit_d      = 1'b1;
          hit_idx_d  = smp_rdata_q.pos;
          hit_code_d = smp_rdata_q.code;
          if (deeper) begin
            r_d     = m_q - SIW'(1);
            level_d = level_q + 4'd1;
          end else begin
            lo_rd_d   = l_q > 0;
            lo_addr_d = SAW'(l_q - SIW'(1));
            hi_rd_d   = 1'b1;
            hi_addr_d = SAW'(r_q);
          end
        end else begin
          if (deeper) begin
            l_d     = m_q + SIW'(1);
            level_d = level_q + 4'd1;
          end else begin
            lo_rd_d   = 1'b1;
            lo_addr_d = SAW'(l_q);
            hi_rd_d   = r_inc_ok;
            hi_addr_d = SAW'(r_inc);
          end
        end
      end
      ST_LO_RD: begin
        pend_d = 1'b0;
        if (lo_rd_q) begin
          smp_re    = 1'b1;
          smp_raddr = lo_addr_q;
        end else begin
          lo_d   = IDX_W'(1);
          prev_d = first_code_q;
        end
      end
      ST_LO_DATA: begin
        lo_d   = $signed(IDX_W'(smp_rdata_q.pos)) + IDX_W'(1);
        prev_d = smp_rdata_q.code;
      end
      ST_HI_RD: begin
        if (hi_rd_q) begin
          smp_re    = 1'b1;
          smp_raddr = hi_addr_q;
        end else begin
          hi_d = $signed(IDX_W'(code_count_q)) - IDX_W'(1);
        end
      end
      ST_HI_DATA: begin
        hi_d = $signed(IDX_W'(smp_rdata_q.pos)) - IDX_W'(1);
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_d      = 1'b1;
          hit_idx_d  = pend_idx_q;
          hit_code_d = sum;
        end else if (pend_q) begin
          prev_d = sum;
        end
        pend_d = issue;
        if (issue) begin
          dlt_re     = 1'b1;
          dlt_raddr  = DAW'(lo_q);
          pend_idx_d = lo_q[POS_W-1:0];
          lo_d       = lo_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = hit_q;
          out_idx_d   = hit_q ? hit_idx_q : '0;
          out_code_d  = hit_q ? hit_code_q : '1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qcode_q    <= qcode_d;
    l_q        <= l_d;
    r_q        <= r_d;
    m_q        <= m_d;
    level_q    <= level_d;
    lo_rd_q    <= lo_rd_d;
    hi_rd_q    <= hi_rd_d;
    lo_addr_q  <= lo_addr_d;
    hi_addr_q  <= hi_addr_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    prev_q     <= prev_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_code_q <= hit_code_d;
    out_found_q <= out_found_d;
    out_idx_q  <= out_idx_d;
    out_code_q <= out_code_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(SAMPLE_ENTRIES))
    else $error("sample fill beyond store size");

  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_SCAN)
    else $error("difference read pending outside scan");

  a_srch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> (l_q <= m_q && m_q <= r_q))
    else $error("search midpoint outside interval");

  a_miss_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[47:16] == '1 && m_axis_tdata[15:0] == '0))
    else $error("miss result with wrong payload");

endmodule

`default_nettype wire

/* test/delta_coded_successor_search_tb.sv */
// delta_coded_successor_search_tb: self-checking bench for the delta-coded successor search
// scoreboard class predicts each query answer from its own copy of samples and difference words
// depends on dcss_pkg and delta_coded_successor_search
`timescale 1ns / 100ps

module delta_coded_successor_search_tb;
  import dcss_pkg::*;

  localparam int SAMPLE_SLOTS = 1024;
  localparam int LIST_SLOTS   = 65536;
  localparam int READ_LIMIT   = 700;
  localparam int FILL_LIMIT   = 40;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic        found;
    logic [15:0] index;
    logic [31:0] code;
  } answer_t;

  class successor_scoreboard;
    logic [15:0] sample_pos   [SAMPLE_SLOTS];
    logic [31:0] sample_code  [SAMPLE_SLOTS];
    int          sample_fill = 0;
    logic [31:0] delta_word   [LIST_SLOTS];
    bit          delta_known  [LIST_SLOTS];
    logic [31:0] planned_word [LIST_SLOTS];
    logic [31:0] first_code   = '0;
    logic [16:0] code_count   = 17'd1;
    logic [31:0] diff_mask    = '1;
    logic [3:0]  search_depth = '0;
    logic        cache_on     = 1'b0;
    int          fill_list [$];
    answer_t     answers_due [$];
    int          errors = 0;

    function void apply_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_FIRST_CODE:   first_code = data;
        REG_CODE_COUNT:   code_count = data[16:0];
        REG_DIFF_MASK:    diff_mask = data;
        REG_SEARCH_DEPTH: search_depth = data[3:0];
        REG_CACHE_ENABLE: cache_on = data[0];
        default: ;
      endcase
    endfunction

    function void low_edge(int l, output int lo, output logic [31:0] prev);
      if (l > 0) begin
        lo = int'(sample_pos[l-1]) + 1;
        prev = sample_code[l-1];
      end else begin
        lo = 1;
        prev = first_code;
      end
    endfunction

    function int high_edge(int r);
      if (r + 1 < sample_fill) return int'(sample_pos[r+1]) - 1;
      return int'(code_count) - 1;
    endfunction

    // in probe mode unwritten words come from the plan and are listed for writing first
    function bit find_successor(logic [31:0] q, bit probe, output answer_t a);
      int l, r, m, lo, hi, level, reads, i;
      bit hit, done;
      logic [15:0] hidx;
      logic [31:0] hcode, prev, d;
      hit = 1'b0;
      hidx = '0;
      hcode = '1;
      reads = 0;
      fill_list.delete();
      a.found = 1'b1;
      a.index = '0;
      a.code = first_code;
      if (q <= first_code) return 1'b1;
      lo = 1;
      prev = first_code;
      hi = int'(code_count) - 1;
      if (cache_on && sample_fill > 0) begin
        l = 0;
        r = sample_fill - 1;
        level = 0;
        done = 1'b0;
        while (!done) begin
          if (l > r) begin
            low_edge(l, lo, prev);
            hi = high_edge(r);
            done = 1'b1;
          end else begin
            m = l + (r - l) / 2;
            if (q < sample_code[m]) begin
              hit = 1'b1;
              hidx = sample_pos[m];
              hcode = sample_code[m];
              if (level < int'(search_depth)) r = m - 1;
              else begin
                low_edge(l, lo, prev);
                hi = int'(sample_pos[r]) - 1;
                done = 1'b1;
              end
            end else if (q > sample_code[m]) begin
              if (level < int'(search_depth)) l = m + 1;
              else begin
                lo = int'(sample_pos[l]) + 1;
                prev = sample_code[l];
                hi = high_edge(r);
                done = 1'b1;
              end
            end else begin
              a.index = sample_pos[m];
              a.code = sample_code[m];
              return 1'b1;
            end
            level++;
          end
        end
      end
      if (hi > LIST_SLOTS - 1) hi = LIST_SLOTS - 1;
      for (i = lo; i <= hi; i++) begin
        if (delta_known[i]) d = delta_word[i];
        else if (probe) begin
          d = planned_word[i];
          fill_list.push_back(i);
        end else d = '0;
        reads++;
        if (probe && (reads > READ_LIMIT || fill_list.size() > FILL_LIMIT)) return 1'b0;
        prev = prev + (d & diff_mask);
        if (q <= prev) begin
          hit = 1'b1;
          hidx = 16'(i);
          hcode = prev;
          break;
        end
      end
      a.found = hit;
      a.index = hit ? hidx : 16'd0;
      a.code = hit ? hcode : 32'hFFFF_FFFF;
      return 1'b1;
    endfunction

    function void note_request(logic [1:0] kind, logic [15:0] pos, logic [31:0] value);
      answer_t a;
      case (kind)
        REQ_SAMPLE: if (sample_fill < SAMPLE_SLOTS) begin
          sample_pos[sample_fill] = pos;
          sample_code[sample_fill] = value;
          sample_fill++;
        end
        REQ_DELTA: begin
          delta_word[pos] = value;
          delta_known[pos] = 1'b1;
        end
        REQ_QUERY: begin
          void'(find_successor(value, 1'b0, a));
          answers_due.push_back(a);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(logic found, logic [15:0] index, logic [31:0] code);
      answer_t want;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found=%0b index=%0d code=%h", found, index, code);
        return;
      end
      want = answers_due.pop_front();
      if (want.found !== found || want.index !== index || want.code !== code) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected found=%0b index=%0d code=%h, got found=%0b index=%0d code=%h",
                   want.found, want.index, want.code, found, index, code);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // position[15:0], value[47:16]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // found_index[15:0], found_code[47:16]
  logic        m_axis_tuser;        // found[0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  successor_scoreboard sb;
  logic [31:0] planned_code [LIST_SLOTS];
  int sent_count = 0;
  int src_idle_pct = 13;
  int sink_idle_pct = 60;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;

  delta_coded_successor_search u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** delta_coded_successor_search: FAILED **");
      $finish;
    end
  end

  // long hold-offs are counted here, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_answer(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16]);
  end

  function automatic void rebuild_codes();
    int i;
    planned_code[0] = sb.first_code;
    for (i = 1; i < LIST_SLOTS; i++)
      planned_code[i] = planned_code[i-1] + (sb.planned_word[i] & sb.diff_mask);
  endfunction

  function automatic logic [31:0] pick_query_code(int span);
    int t, sel;
    logic [31:0] c;
    sel = $urandom_range(99);
    if (sel < 40) t = $urandom_range((span < 512) ? span - 1 : 511);
    else if (sel < 80 && sb.sample_fill > 0) begin
      t = int'(sb.sample_pos[$urandom_range(sb.sample_fill - 1)]) + $urandom_range(7);
      if (t >= span) t = span - 1;
    end else t = $urandom_range(span - 1);
    c = planned_code[t];
    sel = $urandom_range(99);
    if (sel < 15) c = c + 1;
    else if (sel < 25) c = c - 1;
    else if (sel < 35 && sb.sample_fill > 0) c = sb.sample_code[$urandom_range(sb.sample_fill - 1)];
    else if (sel < 40) c = $urandom;
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_item(logic [1:0] kind, logic [15:0] pos, logic [31:0] value);
    sent_count++;
    if (sent_count < 700) begin
      src_idle_pct = 13;
      sink_idle_pct = 60;
    end else if (sent_count < 1400) begin
      src_idle_pct = 60;
      sink_idle_pct = 13;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {value, pos};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(kind, pos, value);
    @(negedge clk_i);
  endtask

  // difference words the query would read unwritten are sent first
  task automatic issue_query(logic [31:0] code);
    answer_t probe;
    int fills [$];
    void'(sb.find_successor(code, 1'b1, probe));
    fills = sb.fill_list;
    foreach (fills[j]) send_item(REQ_DELTA, 16'(fills[j]), sb.planned_word[fills[j]]);
    send_item(REQ_QUERY, 16'($urandom), code);
  endtask

  task automatic send_query(int span);
    answer_t probe;
    logic [31:0] code;
    int tries;
    bit ok;
    ok = 1'b0;
    for (tries = 0; tries < 16 && !ok; tries++) begin
      code = pick_query_code(span);
      ok = sb.find_successor(code, 1'b1, probe);
    end
    if (!ok) code = sb.first_code;
    issue_query(code);
  endtask

  task automatic run_queries(int n, int span);
    repeat (n) send_query(span);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [31:0] first, logic [16:0] count, logic [31:0] mask,
                            logic [3:0] depth, logic enable);
    s_axis_tvalid <= 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_reg(REG_FIRST_CODE, first);
    write_reg(REG_CODE_COUNT, 32'(count));
    write_reg(REG_DIFF_MASK, mask);
    write_reg(REG_SEARCH_DEPTH, 32'(depth));
    write_reg(REG_CACHE_ENABLE, 32'(enable));
    cfg_valid_i <= 1'b0;
    rebuild_codes();
  endtask

  initial begin
    int k, pos, sel;
    logic [31:0] base;
    int depths [4];
    depths[0] = 0;
    depths[1] = 2;
    depths[2] = 5;
    depths[3] = 9;
    sb = new();
    for (k = 0; k < LIST_SLOTS; k++)
      sb.planned_word[k] = ($urandom_range(15) == 0) ? 32'd0 : 32'($urandom_range(1200, 1));
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    rebuild_codes();

    // reset settings: one-entry list
    send_item(REQ_QUERY, 16'hFFFF, 32'h0000_0000);
    send_item(REQ_QUERY, 16'h0000, 32'hFFFF_FFFF);
    send_item(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(REQ_DELTA, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(REQ_DELTA, 16'h0000, 32'h0000_0000);

    // cache on but empty
    set_config(32'd1000, 17'd16, '1, 4'd0, 1'b1);
    issue_query(32'd999);
    issue_query(32'd1000);
    issue_query(planned_code[5]);
    issue_query(planned_code[5] + 1);
    issue_query(32'hFFFF_FFFF);

    // fill the sample store along the list, then one sample too many
    base = 32'($urandom_range(32'h000F_FFFF));
    set_config(base, 17'h1_0000, '1, 4'd9, 1'b1);
    for (k = 0; k < SAMPLE_SLOTS; k++) begin
      pos = (k == 0) ? 0 : k * 64 + $urandom_range(63);
      send_item(REQ_SAMPLE, 16'(pos), planned_code[pos]);
      if (k % 16 == 15) send_query((pos + 64 > LIST_SLOTS) ? LIST_SLOTS : pos + 64);
    end
    send_item(REQ_SAMPLE, 16'($urandom), $urandom);

    foreach (depths[d]) begin
      set_config(base, 17'h1_0000, '1, 4'(depths[d]), 1'b1);
      run_queries(40, LIST_SLOTS);
    end

    set_config(base + 500, 17'd3000, 32'h0000_0FFF, 4'd9, 1'b1);
    run_queries(60, 3000);
    set_config($urandom, 17'd400, '1, 4'd3, 1'b0);
    run_queries(60, 400);
    set_config(32'hFFFF_FF00, 17'd300, '1, 4'd4, 1'b0);
    run_queries(40, 300);
    set_config(32'hFFFF_FFFF, 17'd1, 32'h0, 4'd0, 1'b1);
    run_queries(15, 1);
    set_config(32'h0, 17'd200, 32'h0, 4'd9, 1'b0);
    run_queries(15, 200);

    // receiver stalls for a long stretch while requests keep coming
    set_config(base, 17'h1_0000, '1, 4'd9, 1'b1);
    hold_request = 400;
    for (k = 0; k < 150; k++) begin
      sel = $urandom_range(99);
      if (sel < 70) send_query(LIST_SLOTS);
      else if (sel < 80) send_item(REQ_DELTA, 16'($urandom), $urandom);
      else if (sel < 90) send_item(REQ_UNUSED, 16'($urandom), $urandom);
      else send_item(REQ_SAMPLE, 16'($urandom), $urandom);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.answers_due.size() == 0)
      $display("** delta_coded_successor_search: PASSED **");
    else
      $display("** delta_coded_successor_search: FAILED **");
    $finish;
  end

endmodule
